FILE: sv/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg: shared types and constants for the stable insertion sorter
// Holds list size, value width, cell control struct and the sequencer states.
// ----------------------------------------------------------------------------
package sis_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int MIN_EMIT    = 2;
	localparam int POS_W       = 5;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic [CNT_W-1:0]              count_t;
	typedef logic [IDX_W-1:0]              idx_t;
	typedef logic [POS_W-1:0]              pos_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic insert;    // insertion cycle
		logic rotate;    // output transfer: rotate occupied cells by one
		logic occupied;  // cell index below the current count
		logic at_count;  // cell index equals the current count (first free)
	} cell_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

endpackage

FILE: sv/sis_if.sv
// ----------------------------------------------------------------------------
// sis_if: valid/ready channels of the stable insertion sorter
// Input channel carries a value and a start flag; output channel one element.
// ----------------------------------------------------------------------------
interface sis_in_if import sis_pkg::*; ();
	logic   valid;
	logic   ready;
	value_t value;
	logic   start_new;

	modport source (output valid, value, start_new, input ready);
	modport sink   (input valid, value, start_new, output ready);
endinterface

interface sis_out_if import sis_pkg::*; ();
	logic   valid;
	logic   ready;
	value_t sorted_value;
	pos_t   position;
	logic   last;
	logic   overflow;

	modport source (output valid, sorted_value, position, last, overflow, input ready);
	modport sink   (input valid, sorted_value, position, last, overflow, output ready);
endinterface

FILE: sv/stable_insertion_sorter.sv
// ----------------------------------------------------------------------------
// stable_insertion_sorter: kept ascending list with stable insertion
// Inserts one signed value per input transfer, then streams out the list.
// ----------------------------------------------------------------------------
// The list lives in a row of MAX_ENTRIES cells. On an input transfer every
// cell compares against the new value at once and the larger entries move up
// by one place. When the list then holds two or more entries, it is streamed
// out one element per output transfer, lowest first, by rotating the occupied
// cells toward cell 0, which restores the list after a full pass. All elements
// leave through the single output port of the cell row; input is held off
// until the last element has transferred. A start flag empties the list first;
// a value arriving at a full list is dropped and the list is sent again with
// overflow set on every element.
// ----------------------------------------------------------------------------
module stable_insertion_sorter import sis_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	sis_in_if.sink          din,
	sis_out_if.source       dout
);

	state_t     state_q, state_d;
	count_t     count_q, count_d;
	idx_t       pos_q, pos_d;
	logic       ovf_q, ovf_d;

	logic       in_xfer, out_xfer, is_last;
	count_t     eff_count, occ_count;
	logic       full;

	value_t     cell_value  [MAX_ENTRIES];
	logic       cell_larger [MAX_ENTRIES];
	cell_ctrl_t cell_ctrl   [MAX_ENTRIES];

	assign din.ready  = (state_q == ST_IDLE);
	assign in_xfer    = din.valid && din.ready;
	assign out_xfer   = dout.valid && dout.ready;

	assign eff_count  = din.start_new ? '0 : count_q;
	assign full       = (eff_count == CNT_W'(MAX_ENTRIES));
	assign occ_count  = (state_q == ST_IDLE) ? eff_count : count_q;
	assign is_last    = (CNT_W'(pos_q) == count_q - CNT_W'(1));

	assign dout.valid        = (state_q == ST_EMIT);
	assign dout.sorted_value = cell_value[0];
	assign dout.position     = POS_W'(pos_q);
	assign dout.last         = is_last;
	assign dout.overflow     = ovf_q;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		value_t left_v, right_v;
		logic   left_l;

		if (i == 0) begin : g_head
			assign left_v = din.value;
			assign left_l = 1'b0;
		end else begin : g_body
			assign left_v = cell_value[i-1];
			assign left_l = cell_larger[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign right_v = cell_value[0];
		end else begin : g_mid
			// last occupied cell wraps to the head
			assign right_v = (CNT_W'(i) == count_q - CNT_W'(1)) ? cell_value[0]
			                                                     : cell_value[i+1];
		end

		always_comb begin
			cell_ctrl[i].insert   = in_xfer && !full;
			cell_ctrl[i].rotate   = out_xfer;
			cell_ctrl[i].occupied = (CNT_W'(i) < occ_count);
			cell_ctrl[i].at_count = (CNT_W'(i) == occ_count);
		end

		sis_cell u_cell (
			.clk         (clk),
			.ctrl        (cell_ctrl[i]),
			.new_value   (din.value),
			.left_value  (left_v),
			.left_larger (left_l),
			.right_value (right_v),
			.value       (cell_value[i]),
			.larger      (cell_larger[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pos_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pos_q   <= pos_d;
			ovf_q   <= ovf_d;
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		pos_d   = pos_q;
		ovf_d   = ovf_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					count_d = full ? eff_count : eff_count + CNT_W'(1);
					ovf_d   = full;
					pos_d   = '0;
					if (count_d >= CNT_W'(MIN_EMIT)) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (out_xfer) begin
					pos_d = pos_q + IDX_W'(1);
					if (is_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/sis_cell.sv
// ----------------------------------------------------------------------------
// sis_cell: one slot of the sorted list
// Compares its entry with the incoming value, takes the left neighbor's entry
// or the new value on insertion, and takes the right neighbor's on rotation.
// ----------------------------------------------------------------------------
module sis_cell import sis_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  value_t     new_value,
	input  value_t     left_value,
	input  logic       left_larger,
	input  value_t     right_value,
	output value_t     value,
	output logic       larger
);

	value_t value_q;

	// strictly greater keeps equal entries ahead of the new one
	assign larger = ctrl.occupied && (value_q > new_value);
	assign value  = value_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (left_larger) begin
				value_q <= left_value;
			end else if (larger || ctrl.at_count) begin
				value_q <= new_value;
			end
		end else if (ctrl.rotate && ctrl.occupied) begin
			value_q <= right_value;
		end
	end

endmodule
